### design/lrd_pkg.sv
// lrd_pkg: shared constants, result kind codes and the bundle types of the
// log record deframer. No dependencies.
package lrd_pkg;

	// header layout and checks
	localparam int unsigned HDR_LEN     = 19;
	localparam int unsigned FILL_W      = 5;
	localparam logic [7:0]  LOG_MARK    = 8'h6C;
	localparam logic [7:0]  LOG_ID_MAX  = 8'd7;
	localparam logic [7:0]  PRIO_MIN    = 8'd2;
	localparam logic [7:0]  PRIO_MAX    = 8'd7;
	localparam logic [31:0] NANOS_LIMIT = 32'd1000000000;

	// result kinds
	typedef enum logic [2:0] {
		KIND_HEADER     = 3'd0,
		KIND_TAG        = 3'd1,
		KIND_MSG        = 3'd2,
		KIND_END        = 3'd3,
		KIND_TRUNC      = 3'd4,
		KIND_REC_TALLY  = 3'd5,
		KIND_SKIP_TALLY = 3'd6
	} kind_t;

	// bits of the pending result mask, in emission order
	localparam int unsigned RB_PRIM  = 0;
	localparam int unsigned RB_END   = 1;
	localparam int unsigned RB_TRUNC = 2;
	localparam int unsigned RB_RTAL  = 3;
	localparam int unsigned RB_STAL  = 4;
	localparam int unsigned RB_N     = 5;

	// header, tag or message result with all its fields
	typedef struct packed {
		kind_t       kind;
		logic [2:0]  log_id;
		logic [2:0]  priority_res;
		logic [15:0] user_id;
		logic [15:0] process_id;
		logic [15:0] thread_id;
		logic [31:0] stamp_seconds;
		logic [29:0] stamp_nanos;
		logic [7:0]  out_byte;
		logic [31:0] count;
	} prim_res_t;

	// result set of one byte, handed from the framer to the sequencer
	typedef struct packed {
		logic             load;
		logic [RB_N-1:0]  mask;
		prim_res_t        prim;
		logic [31:0]      rec_tally;
		logic [31:0]      skip_tally;
	} res_load_t;

endpackage

### design/lrd_if.sv
// lrd_byte_if and lrd_result_if: valid/ready channels of the log record
// deframer. Depends on nothing.
interface lrd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source(output valid, data_byte, final_byte, input ready);
	modport sink(input valid, data_byte, final_byte, output ready);
endinterface

interface lrd_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [2:0]  log_id;
	logic [2:0]  priority_res;
	logic [15:0] user_id;
	logic [15:0] process_id;
	logic [15:0] thread_id;
	logic [31:0] stamp_seconds;
	logic [29:0] stamp_nanos;
	logic [7:0]  out_byte;
	logic [31:0] count;
	logic        last_of_run;

	modport source(output valid, kind, log_id, priority_res, user_id, process_id,
		thread_id, stamp_seconds, stamp_nanos, out_byte, count, last_of_run,
		input ready);
	modport sink(input valid, kind, log_id, priority_res, user_id, process_id,
		thread_id, stamp_seconds, stamp_nanos, out_byte, count, last_of_run,
		output ready);
endinterface

### design/lrd_framer.sv
// lrd_framer: input register, header window, record state and tallies; builds
// the result set of each byte. Depends on lrd_pkg and lrd_byte_if.
module lrd_framer #(
	parameter int unsigned MAX_PAYLOAD = 4068
) (
	input  logic               clk,
	input  logic               arst_n,
	lrd_byte_if.sink           in_ch,
	input  logic               can_load,
	output lrd_pkg::res_load_t load
);

	localparam int unsigned PL_W = $clog2(MAX_PAYLOAD + 1);
	localparam logic [16:0] LEN_MAX = 17'(lrd_pkg::HDR_LEN + MAX_PAYLOAD);
	localparam logic [15:0] LEN_MIN = 16'(lrd_pkg::HDR_LEN);
	localparam logic [lrd_pkg::FILL_W-1:0] FILL_FULL = lrd_pkg::FILL_W'(lrd_pkg::HDR_LEN);
	localparam logic [lrd_pkg::FILL_W-1:0] FILL_SLID =
		lrd_pkg::FILL_W'(lrd_pkg::HDR_LEN - 1);

	// input register
	logic [7:0] data_s1;
	logic       fin_s1;
	logic       valid_s1;
	logic       step;

	assign step        = valid_s1 && can_load;
	assign in_ch.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_s1 <= in_ch.data_byte;
			fin_s1  <= in_ch.final_byte;
		end
	end

	// record state
	logic [7:0]                win_q [lrd_pkg::HDR_LEN];
	logic [lrd_pkg::FILL_W-1:0] fill_q;
	logic                      in_rec_q;
	logic                      in_msg_q;
	logic [PL_W-1:0]           payload_q;
	logic [PL_W-1:0]           nuls_q;
	logic [31:0]               rec_tally_q;
	logic [31:0]               skip_tally_q;

	logic [7:0]                win_n [lrd_pkg::HDR_LEN];
	logic [lrd_pkg::FILL_W-1:0] fill_inc;
	logic                      window_full;
	logic                      hdr_ok;
	logic                      hdr_accept;
	logic                      skip;
	logic                      nul;
	logic                      tag_byte;
	logic                      msg_byte;
	logic                      rec_end;
	logic                      trunc;
	logic [15:0]               len;
	logic [31:0]               nanos;
	logic [PL_W-1:0]           pay_new;
	logic [31:0]               rt_n;
	logic [31:0]               st_n;

	// window fill with the new byte
	always_comb begin
		win_n    = win_q;
		fill_inc = fill_q;
		if (!in_rec_q && fill_q < FILL_FULL) begin
			win_n[fill_q] = data_s1;
			fill_inc      = fill_q + 1'b1;
		end
	end

	// header checks on the filled window
	assign len     = {win_n[2], win_n[1]};
	assign nanos   = {win_n[17], win_n[16], win_n[15], win_n[14]};
	assign pay_new = PL_W'(len - LEN_MIN);
	assign hdr_ok  = (win_n[0] == lrd_pkg::LOG_MARK) && (len > LEN_MIN) &&
		({1'b0, len} <= LEN_MAX) && (win_n[7] <= lrd_pkg::LOG_ID_MAX) &&
		(nanos < lrd_pkg::NANOS_LIMIT) && (win_n[18] >= lrd_pkg::PRIO_MIN) &&
		(win_n[18] <= lrd_pkg::PRIO_MAX);

	assign window_full = !in_rec_q && (fill_inc == FILL_FULL);
	assign hdr_accept  = window_full && hdr_ok;
	assign skip        = window_full && !hdr_ok;

	// payload byte classes
	assign nul      = (data_s1 == 8'd0);
	assign tag_byte = in_rec_q && !in_msg_q && !nul;
	assign msg_byte = in_rec_q && in_msg_q && !nul;
	assign rec_end  = in_rec_q && (payload_q == PL_W'(1));
	assign trunc    = fin_s1 && ((in_rec_q && !rec_end) || hdr_accept);
	assign rt_n     = rec_tally_q + 32'(rec_end);
	assign st_n     = skip_tally_q + 32'(skip);

	// result set for the sequencer
	always_comb begin
		load                     = '0;
		load.load                = step;
		load.mask[lrd_pkg::RB_PRIM]  = hdr_accept || tag_byte || msg_byte;
		load.mask[lrd_pkg::RB_END]   = rec_end;
		load.mask[lrd_pkg::RB_TRUNC] = trunc;
		load.mask[lrd_pkg::RB_RTAL]  = fin_s1;
		load.mask[lrd_pkg::RB_STAL]  = fin_s1;
		load.rec_tally           = rt_n;
		load.skip_tally          = st_n;
		if (hdr_accept) begin
			load.prim.kind          = lrd_pkg::KIND_HEADER;
			load.prim.log_id        = win_n[7][2:0];
			load.prim.priority_res  = win_n[18][2:0];
			load.prim.user_id       = {win_n[4], win_n[3]};
			load.prim.process_id    = {win_n[6], win_n[5]};
			load.prim.thread_id     = {win_n[9], win_n[8]};
			load.prim.stamp_seconds = {win_n[13], win_n[12], win_n[11], win_n[10]};
			load.prim.stamp_nanos   = nanos[29:0];
		end else if (tag_byte) begin
			load.prim.kind     = lrd_pkg::KIND_TAG;
			load.prim.out_byte = data_s1;
		end else begin
			load.prim.kind     = lrd_pkg::KIND_MSG;
			load.prim.out_byte = msg_byte ? data_s1 : 8'd0;
			load.prim.count    = msg_byte ? 32'(nuls_q) : 32'd0;
		end
	end

	// control state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			in_rec_q     <= 1'b0;
			in_msg_q     <= 1'b0;
			payload_q    <= '0;
			nuls_q       <= '0;
			rec_tally_q  <= '0;
			skip_tally_q <= '0;
		end else if (step) begin
			if (fin_s1) begin
				fill_q       <= '0;
				in_rec_q     <= 1'b0;
				in_msg_q     <= 1'b0;
				payload_q    <= '0;
				nuls_q       <= '0;
				rec_tally_q  <= '0;
				skip_tally_q <= '0;
			end else begin
				rec_tally_q  <= rt_n;
				skip_tally_q <= st_n;
				if (in_rec_q) begin
					payload_q <= payload_q - 1'b1;
					if (rec_end) begin
						in_rec_q <= 1'b0;
						in_msg_q <= 1'b0;
						nuls_q   <= '0;
					end else if (!in_msg_q) begin
						if (nul) begin
							in_msg_q <= 1'b1;
						end
					end else if (nul) begin
						nuls_q <= nuls_q + 1'b1;
					end else begin
						nuls_q <= '0;
					end
				end else if (hdr_accept) begin
					in_rec_q  <= 1'b1;
					in_msg_q  <= 1'b0;
					nuls_q    <= '0;
					payload_q <= pay_new;
					fill_q    <= '0;
				end else if (skip) begin
					fill_q <= FILL_SLID;
				end else begin
					fill_q <= fill_inc;
				end
			end
		end
	end

	// header window: fill, or slide by one byte on a failed check
	always_ff @(posedge clk) begin
		if (step && !in_rec_q) begin
			if (skip) begin
				for (int i = 0; i < lrd_pkg::HDR_LEN - 1; i++) begin
					win_q[i] <= win_n[i + 1];
				end
				win_q[lrd_pkg::HDR_LEN - 1] <= 8'd0;
			end else begin
				win_q <= win_n;
			end
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL)
		else $error("window fill beyond header length");
	a_rec_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_rec_q |-> (fill_q == '0) && (payload_q != '0))
		else $error("record active with window fill or no payload left");
	a_msg_in_rec: assert property (@(posedge clk) disable iff (!arst_n)
		in_msg_q |-> in_rec_q)
		else $error("message phase outside record");
	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && fin_s1 |=> !in_rec_q && (fill_q == '0) && (rec_tally_q == '0))
		else $error("end of buffer did not restore reset state");

endmodule

### design/lrd_result_seq.sv
// lrd_result_seq: holds the result set of one byte and emits its results in
// order, one per request. Depends on lrd_pkg and lrd_result_if.
module lrd_result_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  lrd_pkg::res_load_t load,
	output logic               can_load,
	lrd_result_if.source       out_ch
);

	logic [lrd_pkg::RB_N-1:0] mask_q;
	lrd_pkg::prim_res_t       prim_q;
	logic [31:0]              rt_q;
	logic [31:0]              st_q;

	logic [lrd_pkg::RB_N-1:0] lowest;
	logic                     single;
	logic                     pop;
	lrd_pkg::prim_res_t       sel;

	assign lowest   = mask_q & (~mask_q + 1'b1);
	assign single   = (mask_q & (mask_q - 1'b1)) == '0;
	assign pop      = out_ch.valid && out_ch.ready;
	assign can_load = (mask_q == '0) || (single && pop);

	// pending mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load.load) begin
			mask_q <= load.mask;
		end else if (pop) begin
			mask_q <= mask_q & ~lowest;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load.load) begin
			prim_q <= load.prim;
			rt_q   <= load.rec_tally;
			st_q   <= load.skip_tally;
		end
	end

	// pick the first pending result
	always_comb begin
		sel = '0;
		priority if (mask_q[lrd_pkg::RB_PRIM]) begin
			sel = prim_q;
		end else if (mask_q[lrd_pkg::RB_END]) begin
			sel.kind = lrd_pkg::KIND_END;
		end else if (mask_q[lrd_pkg::RB_TRUNC]) begin
			sel.kind = lrd_pkg::KIND_TRUNC;
		end else if (mask_q[lrd_pkg::RB_RTAL]) begin
			sel.kind  = lrd_pkg::KIND_REC_TALLY;
			sel.count = rt_q;
		end else if (mask_q[lrd_pkg::RB_STAL]) begin
			sel.kind  = lrd_pkg::KIND_SKIP_TALLY;
			sel.count = st_q;
		end else begin
			sel = '0;
		end
	end

	assign out_ch.valid         = mask_q != '0;
	assign out_ch.kind          = sel.kind;
	assign out_ch.log_id        = sel.log_id;
	assign out_ch.priority_res  = sel.priority_res;
	assign out_ch.user_id       = sel.user_id;
	assign out_ch.process_id    = sel.process_id;
	assign out_ch.thread_id     = sel.thread_id;
	assign out_ch.stamp_seconds = sel.stamp_seconds;
	assign out_ch.stamp_nanos   = sel.stamp_nanos;
	assign out_ch.out_byte      = sel.out_byte;
	assign out_ch.count         = sel.count;
	assign out_ch.last_of_run   = out_ch.valid && single;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load.load |-> (mask_q == '0) || (single && pop))
		else $error("result set loaded over pending results");
	a_end_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		!(mask_q[lrd_pkg::RB_END] && mask_q[lrd_pkg::RB_TRUNC]))
		else $error("record end and truncation in one result set");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && single && !load.load |=> mask_q == '0)
		else $error("last result taken but set not empty");

endmodule

### design/log_record_deframer_unit.sv
// log_record_deframer_unit: top level of the log record deframer; framer and
// result sequencer. Depends on lrd_pkg, lrd_if, lrd_framer, lrd_result_seq.
// Path: a byte passes the input register, then the sequencer's pending mask.
// Throughput: one byte per cycle while each byte causes at most one result and
// out_ch.ready is high; a byte with k results (k up to 4) holds the result port.
// Reset: arst_n clears the window fill, record state, tallies and all valids.
module log_record_deframer_unit #(
	parameter int unsigned MAX_PAYLOAD = 4068
) (
	input logic          clk,
	input logic          arst_n,
	lrd_byte_if.sink     in_ch,
	lrd_result_if.source out_ch
);

	lrd_pkg::res_load_t load;
	logic               can_load;

	lrd_framer #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.can_load(can_load),
		.load    (load)
	);

	lrd_result_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.can_load(can_load),
		.out_ch  (out_ch)
	);

endmodule
